[design/opp_pkg.sv]
// shared constants, tables and helpers for the obex packet parser
package opp_pkg;

    typedef logic [1:0] t_event_kind;

    localparam t_event_kind EV_HEAD    = 2'd0;
    localparam t_event_kind EV_CONNECT = 2'd1;
    localparam t_event_kind EV_SETPATH = 2'd2;
    localparam t_event_kind EV_HEADER  = 2'd3;

    localparam logic [6:0] OP_CONNECT    = 7'h00;
    localparam logic [6:0] OP_DISCONNECT = 7'h01;
    localparam logic [6:0] OP_PUT        = 7'h02;
    localparam logic [6:0] OP_GET        = 7'h03;
    localparam logic [6:0] OP_SETPATH    = 7'h05;
    localparam logic [6:0] OP_ABORT      = 7'h7F;
    localparam logic [6:0] REQ_LIMIT     = 7'h10;

    localparam logic [1:0] CLS_UNICODE = 2'd0;
    localparam logic [1:0] CLS_BYTES   = 2'd1;

    localparam logic [7:0]  HID_TARGET     = 8'h46;
    localparam logic [7:0]  HID_WHO        = 8'h4A;
    localparam logic [15:0] TARGET_HDR_LEN = 16'd19;
    localparam logic [15:0] MIN_LEN        = 16'd3;
    localparam logic [15:0] MIN_XML_LEN    = 16'd8;
    localparam logic [15:0] XML_MARK_LEN   = 16'd5;

    localparam int UUID_ROWS = 11;

    localparam logic [0:UUID_ROWS-1][0:15][7:0] UUID_TABLE = {
        128'hF9EC7BC4_953C11D2_984E5254_00DC9E09,
        128'h796135F0_F0C511D8_09660800_200C9A66,
        128'h00000001_00001000_80000002_EE000002,
        128'hE33D9545_83744AD7_9EC5C16B_E31EDE8E,
        128'h8EE9B3D0_460811D5_841A0002_A5325B4E,
        128'h92353350_460811D5_841A0002_A5325B4E,
        128'h940126C0_460811D5_841A0002_A5325B4E,
        128'h947E7420_460811D5_841A0002_A5325B4E,
        128'h94C7CD20_460811D5_841A0002_A5325B4E,
        128'h8E61F95D_1A7911D4_8EA40080_5F9B9834,
        128'h8E61F95D_1A7911D4_8EA40080_5F9B9834
    };

    // expected bytes of the "<?xml" mark
    function automatic logic [7:0] xml_mark(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h3C;
            3'd1:    v = 8'h3F;
            3'd2:    v = 8'h78;
            3'd3:    v = 8'h6D;
            3'd4:    v = 8'h6C;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic byte_is_plain(input logic [7:0] b);
        return (b >= 8'h20) || (b == 8'h0A);
    endfunction

    function automatic logic code_is_request(input logic [6:0] c);
        return (c < REQ_LIMIT) || (c == OP_ABORT);
    endfunction

endpackage

[design/obex_packet_parser_unit.sv]
// obex packet header parser: one stream byte per cycle in, one event register out
//
// Takes one byte of an OBEX packet stream in every cycle and gives at most one event
// per byte: packet head, connect parameters, setpath parameters or a completed header.
// All parsing of a byte is done in the cycle it is accepted, by the phase sequencer and
// its byte and length counters, and the event lands in an output register.
// A byte is accepted whenever the output register is empty or is being taken in the
// same cycle, so the sustained rate is one byte per clock with no stall of its own.
// There is no start-up pass after reset. TARGET_ENTRIES limits which uuid table rows
// can show in the target mask.
module obex_packet_parser_unit
    import opp_pkg::*;
#(
    parameter int TARGET_ENTRIES = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_direction,
    input  logic        i_packet_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_kind,
    output logic [6:0]  o_code,
    output logic        o_fin_bit,
    output logic        o_is_request,
    output logic [15:0] o_length_value,
    output logic [31:0] o_field_value,
    output logic [7:0]  o_header_id,
    output logic [10:0] o_target_mask,
    output logic        o_is_text,
    output logic        o_is_xml,
    output logic        o_packet_last,
    output logic        o_event_direction
);

    localparam int ROWS_USED = (TARGET_ENTRIES < UUID_ROWS) ? TARGET_ENTRIES : UUID_ROWS;

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_LEN_HI     = 4'd1;
    localparam logic [3:0] PH_LEN_LO     = 4'd2;
    localparam logic [3:0] PH_CONNECT    = 4'd3;
    localparam logic [3:0] PH_SETPATH    = 4'd4;
    localparam logic [3:0] PH_HDR_ID     = 4'd5;
    localparam logic [3:0] PH_HDR_LEN_HI = 4'd6;
    localparam logic [3:0] PH_HDR_LEN_LO = 4'd7;
    localparam logic [3:0] PH_HDR_VALUE  = 4'd8;

    logic [3:0]  r_phase,    n_phase;
    logic [15:0] r_pkt_cnt,  n_pkt_cnt;
    logic [15:0] r_pkt_len,  n_pkt_len;
    logic [7:0]  r_code,     n_code;
    logic        r_dir,      n_dir;
    logic [6:0]  r_last_req0, n_last_req0;
    logic [6:0]  r_last_req1, n_last_req1;
    logic [15:0] r_hdr_cnt,  n_hdr_cnt;
    logic [15:0] r_hdr_len,  n_hdr_len;
    logic [31:0] r_acc,      n_acc;
    logic [UUID_ROWS-1:0] r_match, n_match;
    logic        r_tx_ok,    n_tx_ok;
    logic        r_tx_null,  n_tx_null;
    logic        r_tx_xml,   n_tx_xml;
    logic [7:0]  r_hid,      n_hid;

    logic        r_out_valid;
    t_event_kind r_ev_kind;
    logic [15:0] r_ev_len;
    logic [31:0] r_ev_fval;
    logic [7:0]  r_ev_hid;
    logic [10:0] r_ev_tmask;
    logic        r_ev_txt;
    logic        r_ev_xml;
    logic        r_ev_last;
    logic [7:0]  r_ev_code;
    logic        r_ev_dir;

    logic        w_accept;
    logic        w_ev;
    t_event_kind w_kind;
    logic [15:0] w_len;
    logic [31:0] w_fval;
    logic [7:0]  w_hid;
    logic [10:0] w_tmask;
    logic        w_txt;
    logic        w_xml;
    logic [6:0]  w_code7;
    logic [6:0]  w_other_last;
    logic [15:0] w_cnt_inc;
    logic [15:0] w_hcnt_inc;
    logic [15:0] w_k;
    logic [15:0] w_len_lo;
    logic [15:0] w_hlen_lo;
    logic [1:0]  w_cls;
    logic [UUID_ROWS-1:0] w_row_miss;
    logic [UUID_ROWS-1:0] w_row_mask;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_code7      = r_code[6:0];
    assign w_other_last = r_dir ? r_last_req0 : r_last_req1;
    assign w_cnt_inc    = r_pkt_cnt + 16'd1;
    assign w_hcnt_inc   = r_hdr_cnt + 16'd1;
    assign w_k          = r_hdr_cnt - MIN_LEN;
    assign w_len_lo     = {r_pkt_len[15:8], i_data_byte};
    assign w_hlen_lo    = {r_hdr_len[15:8], i_data_byte};
    assign w_cls        = r_hid[7:6];

    always_comb begin
        for (int i = 0; i < UUID_ROWS; i++) begin
            w_row_miss[i] = (UUID_TABLE[i][w_k[3:0]] != i_data_byte);
            w_row_mask[i] = (i < ROWS_USED);
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_pkt_cnt   = r_pkt_cnt;
        n_pkt_len   = r_pkt_len;
        n_code      = r_code;
        n_dir       = r_dir;
        n_last_req0 = r_last_req0;
        n_last_req1 = r_last_req1;
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr_len   = r_hdr_len;
        n_acc       = r_acc;
        n_match     = r_match;
        n_tx_ok     = r_tx_ok;
        n_tx_null   = r_tx_null;
        n_tx_xml    = r_tx_xml;
        n_hid       = r_hid;
        w_ev        = 1'b0;
        w_kind      = EV_HEAD;
        w_len       = '0;
        w_fval      = '0;
        w_hid       = '0;
        w_tmask     = '0;
        w_txt       = 1'b0;
        w_xml       = 1'b0;

        if (i_packet_start || r_phase == PH_IDLE) begin
            n_code    = i_data_byte;
            n_dir     = i_direction;
            n_pkt_cnt = 16'd1;
            n_pkt_len = '0;
            n_phase   = PH_LEN_HI;
        end else begin
            n_pkt_cnt = w_cnt_inc;
            unique case (r_phase) inside
                PH_LEN_HI: begin
                    n_pkt_len = {i_data_byte, 8'h00};
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_pkt_len = (w_len_lo < MIN_LEN) ? MIN_LEN : w_len_lo;
                    w_ev      = 1'b1;
                    w_kind    = EV_HEAD;
                    w_len     = n_pkt_len;
                    if (code_is_request(w_code7)) begin
                        if (r_dir) begin
                            n_last_req1 = w_code7;
                        end else begin
                            n_last_req0 = w_code7;
                        end
                    end
                    n_hdr_cnt = '0;
                    n_acc     = '0;
                    if (w_code7 == OP_CONNECT) begin
                        n_phase = PH_CONNECT;
                    end else if (w_code7 == OP_SETPATH) begin
                        n_phase = PH_SETPATH;
                    end else if (w_code7 == OP_DISCONNECT || w_code7 == OP_PUT ||
                                 w_code7 == OP_GET || w_code7 == OP_ABORT) begin
                        n_phase = PH_HDR_ID;
                    end else if (w_other_last == OP_CONNECT) begin
                        // response to a connect from the other side
                        n_phase = PH_CONNECT;
                    end else begin
                        n_phase = PH_HDR_ID;
                    end
                end
                PH_CONNECT, PH_SETPATH: begin
                    n_acc     = {r_acc[23:0], i_data_byte};
                    n_hdr_cnt = w_hcnt_inc;
                    if (r_phase == PH_CONNECT && w_hcnt_inc == 16'd4) begin
                        w_ev    = 1'b1;
                        w_kind  = EV_CONNECT;
                        w_fval  = {16'h0000, n_acc[31:16]};
                        w_len   = n_acc[15:0];
                        n_phase = PH_HDR_ID;
                    end else if (r_phase == PH_SETPATH && w_hcnt_inc == 16'd2) begin
                        w_ev    = 1'b1;
                        w_kind  = EV_SETPATH;
                        w_fval  = {16'h0000, n_acc[15:0]};
                        n_phase = PH_HDR_ID;
                    end
                end
                PH_HDR_ID: begin
                    n_hid     = i_data_byte;
                    n_hdr_cnt = 16'd1;
                    n_acc     = '0;
                    n_match   = '1;
                    n_tx_ok   = 1'b1;
                    n_tx_null = 1'b0;
                    n_tx_xml  = 1'b1;
                    if (i_data_byte[7]) begin
                        // one-byte value or four-byte value, fixed length
                        n_hdr_len = i_data_byte[6] ? 16'd5 : 16'd2;
                        n_phase   = PH_HDR_VALUE;
                    end else begin
                        n_phase = PH_HDR_LEN_HI;
                    end
                end
                PH_HDR_LEN_HI: begin
                    n_hdr_len = {i_data_byte, 8'h00};
                    n_hdr_cnt = 16'd2;
                    n_phase   = PH_HDR_LEN_LO;
                end
                PH_HDR_LEN_LO: begin
                    n_hdr_len = (w_hlen_lo < MIN_LEN) ? MIN_LEN : w_hlen_lo;
                    n_hdr_cnt = MIN_LEN;
                    if (n_hdr_len == MIN_LEN) begin
                        w_ev    = 1'b1;
                        w_kind  = EV_HEADER;
                        w_hid   = r_hid;
                        w_len   = MIN_LEN;
                        n_phase = PH_HDR_ID;
                    end else begin
                        n_phase = PH_HDR_VALUE;
                    end
                end
                PH_HDR_VALUE: begin
                    if (w_cls[1]) begin
                        n_acc = {r_acc[23:0], i_data_byte};
                    end else if (w_cls == CLS_BYTES) begin
                        if (w_k[15:4] == 12'h000) begin
                            n_match = r_match & ~w_row_miss;
                        end
                        if (w_k < XML_MARK_LEN && xml_mark(w_k[2:0]) != i_data_byte) begin
                            n_tx_xml = 1'b0;
                        end
                    end else if (!w_k[0]) begin
                        // unicode high byte, held for the zero-char test
                        n_acc = {24'h000000, i_data_byte};
                    end else if (!r_tx_null) begin
                        if (r_acc == 32'h0 && i_data_byte == 8'h00) begin
                            n_tx_null = 1'b1;
                        end else if (!byte_is_plain(i_data_byte)) begin
                            n_tx_ok = 1'b0;
                        end
                    end
                    n_hdr_cnt = w_hcnt_inc;
                    if (w_hcnt_inc >= r_hdr_len) begin
                        w_ev    = 1'b1;
                        w_kind  = EV_HEADER;
                        w_hid   = r_hid;
                        w_len   = r_hdr_len;
                        n_phase = PH_HDR_ID;
                        if (w_cls[1]) begin
                            w_fval = n_acc;
                        end else if (w_cls == CLS_BYTES) begin
                            w_xml = n_tx_xml && (r_hdr_len >= MIN_XML_LEN);
                            w_txt = !w_xml && r_tx_ok && (i_data_byte == 8'h00);
                            if ((r_hid == HID_TARGET || r_hid == HID_WHO) &&
                                r_hdr_len == TARGET_HDR_LEN) begin
                                w_tmask = 11'(n_match & w_row_mask);
                            end
                        end else begin
                            w_txt = n_tx_null && n_tx_ok;
                        end
                    end else if (w_cls == CLS_BYTES && !byte_is_plain(i_data_byte)) begin
                        n_tx_ok = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // packet closes at its declared length once the length is known
            if (n_phase != PH_IDLE && n_phase != PH_LEN_HI && n_phase != PH_LEN_LO &&
                w_cnt_inc >= n_pkt_len) begin
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pkt_cnt   <= '0;
            r_pkt_len   <= '0;
            r_code      <= '0;
            r_dir       <= 1'b0;
            r_last_req0 <= OP_DISCONNECT;
            r_last_req1 <= OP_DISCONNECT;
            r_hdr_cnt   <= '0;
            r_hdr_len   <= '0;
            r_acc       <= '0;
            r_match     <= '1;
            r_tx_ok     <= 1'b0;
            r_tx_null   <= 1'b0;
            r_tx_xml    <= 1'b0;
            r_hid       <= '0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_pkt_cnt   <= n_pkt_cnt;
            r_pkt_len   <= n_pkt_len;
            r_code      <= n_code;
            r_dir       <= n_dir;
            r_last_req0 <= n_last_req0;
            r_last_req1 <= n_last_req1;
            r_hdr_cnt   <= n_hdr_cnt;
            r_hdr_len   <= n_hdr_len;
            r_acc       <= n_acc;
            r_match     <= n_match;
            r_tx_ok     <= n_tx_ok;
            r_tx_null   <= n_tx_null;
            r_tx_xml    <= n_tx_xml;
            r_hid       <= n_hid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_ev) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_ev) begin
            r_ev_kind  <= w_kind;
            r_ev_len   <= w_len;
            r_ev_fval  <= w_fval;
            r_ev_hid   <= w_hid;
            r_ev_tmask <= w_tmask;
            r_ev_txt   <= w_txt;
            r_ev_xml   <= w_xml;
            r_ev_last  <= (n_phase == PH_IDLE);
            r_ev_code  <= r_code;
            r_ev_dir   <= r_dir;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_kind      = r_ev_kind;
    assign o_code            = r_ev_code[6:0];
    assign o_fin_bit         = r_ev_code[7];
    assign o_is_request      = code_is_request(r_ev_code[6:0]);
    assign o_length_value    = r_ev_len;
    assign o_field_value     = r_ev_fval;
    assign o_header_id       = r_ev_hid;
    assign o_target_mask     = r_ev_tmask;
    assign o_is_text         = r_ev_txt;
    assign o_is_xml          = r_ev_xml;
    assign o_packet_last     = r_ev_last;
    assign o_event_direction = r_ev_dir;

endmodule

[design/opp_checker.sv]
// port-level checks for the obex packet parser and their binding
module opp_checker
    import opp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_direction,
    input logic        i_packet_start,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_event_kind,
    input logic [6:0]  o_code,
    input logic        o_fin_bit,
    input logic        o_is_request,
    input logic [15:0] o_length_value,
    input logic [31:0] o_field_value,
    input logic [7:0]  o_header_id,
    input logic [10:0] o_target_mask,
    input logic        o_is_text,
    input logic        o_is_xml,
    input logic        o_packet_last,
    input logic        o_event_direction
);

    // a stalled event stays valid and holds its kind, length, field value and header id
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_kind) &&
        $stable(o_length_value) && $stable(o_field_value) && $stable(o_header_id))
        else $error("event word changed while stalled");

    a_text_xml: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_text && o_is_xml))
        else $error("value flagged as both text and xml");

    // target mask only on a target or who header of uuid size
    a_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_target_mask != 11'h000 |-> o_event_kind == EV_HEADER &&
        (o_header_id == HID_TARGET || o_header_id == HID_WHO) &&
        o_length_value == TARGET_HDR_LEN)
        else $error("target mask on a non-target event");

    // header fields stay clear on packet-level events, head length never short
    a_non_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind != EV_HEADER |-> o_header_id == 8'h00 &&
        !o_is_text && !o_is_xml && o_target_mask == 11'h000 &&
        (o_event_kind != EV_HEAD || o_length_value >= MIN_LEN))
        else $error("header fields set on a packet-level event");

endmodule

bind obex_packet_parser_unit opp_checker u_opp_checker (.*);

[sim/testbench.sv]
// testbench for the obex packet parser: byte stream stimulus, event prediction and checking
module testbench;
    import opp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam time HALF_PERIOD  = 6ns;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_BYTES  = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 200;

    localparam logic [1:0] CLS_ONE_BYTE  = 2'd2;
    localparam logic [1:0] CLS_FOUR_BYTE = 2'd3;

    localparam logic [39:0] XML_OPENING = 40'h3C3F786D6C;

    localparam int RX_OPEN     = 0;
    localparam int RX_LIGHT    = 1;
    localparam int RX_HEAVY    = 2;
    localparam int RX_PERIODIC = 3;

    typedef enum logic [3:0] {
        PH_IDLE, PH_LEN_HI, PH_LEN_LO, PH_CONNECT, PH_SETPATH,
        PH_HDR_ID, PH_HDR_LEN_HI, PH_HDR_LEN_LO, PH_HDR_VALUE
    } t_parse_phase;

    typedef enum int {BS_TEXT, BS_XML, BS_TARGET, BS_RAW} t_byteseq_style;

    typedef struct packed {
        t_event_kind  kind;
        logic [6:0]   code;
        logic         fin_bit;
        logic         is_request;
        logic [15:0]  length_value;
        logic [31:0]  field_value;
        logic [7:0]   header_id;
        logic [10:0]  target_mask;
        logic         is_text;
        logic         is_xml;
        logic         packet_last;
        logic         direction;
    } t_parser_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_direction = 1'b0;
    logic        i_packet_start = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_event_kind;
    logic [6:0]  o_code;
    logic        o_fin_bit;
    logic        o_is_request;
    logic [15:0] o_length_value;
    logic [31:0] o_field_value;
    logic [7:0]  o_header_id;
    logic [10:0] o_target_mask;
    logic        o_is_text;
    logic        o_is_xml;
    logic        o_packet_last;
    logic        o_event_direction;

    obex_packet_parser_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_direction       (i_direction),
        .i_packet_start    (i_packet_start),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_event_kind      (o_event_kind),
        .o_code            (o_code),
        .o_fin_bit         (o_fin_bit),
        .o_is_request      (o_is_request),
        .o_length_value    (o_length_value),
        .o_field_value     (o_field_value),
        .o_header_id       (o_header_id),
        .o_target_mask     (o_target_mask),
        .o_is_text         (o_is_text),
        .o_is_xml          (o_is_xml),
        .o_packet_last     (o_packet_last),
        .o_event_direction (o_event_direction)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // parser state as predicted
    t_parse_phase phase;
    logic [15:0]  pkt_count;
    logic [15:0]  pkt_len;
    logic [7:0]   cur_code;
    logic [6:0]   last_req [2];
    logic [15:0]  hdr_count;
    logic [15:0]  hdr_len;
    logic [31:0]  acc;
    logic [10:0]  uuid_hits;
    logic         tx_ok;
    logic         tx_nul;
    logic         tx_xml;
    logic         pkt_dir;
    logic [7:0]   hdr_id;

    t_parser_event pending_events[$];
    int error_count = 0;

    // stimulus state
    logic [7:0] frame[$];
    logic [7:0] hdr_value[$];
    int bytes_fed = 0;
    int burst_left = 0;
    logic req_dir = 1'b0;
    logic resync = 1'b1;

    function automatic logic [7:0] uuid_byte(input int row, input int k);
        logic [127:0] r;
        case (row)
            0:  r = 128'hF9EC7BC4_953C11D2_984E5254_00DC9E09;
            1:  r = 128'h796135F0_F0C511D8_09660800_200C9A66;
            2:  r = 128'h00000001_00001000_80000002_EE000002;
            3:  r = 128'hE33D9545_83744AD7_9EC5C16B_E31EDE8E;
            4:  r = 128'h8EE9B3D0_460811D5_841A0002_A5325B4E;
            5:  r = 128'h92353350_460811D5_841A0002_A5325B4E;
            6:  r = 128'h940126C0_460811D5_841A0002_A5325B4E;
            7:  r = 128'h947E7420_460811D5_841A0002_A5325B4E;
            8:  r = 128'h94C7CD20_460811D5_841A0002_A5325B4E;
            default: r = 128'h8E61F95D_1A7911D4_8EA40080_5F9B9834;
        endcase
        return r[127 - 8 * k -: 8];
    endfunction

    task automatic reset_model();
        phase       = PH_IDLE;
        pkt_count   = '0;
        pkt_len     = '0;
        cur_code    = '0;
        last_req[0] = OP_DISCONNECT;
        last_req[1] = OP_DISCONNECT;
        hdr_count   = '0;
        hdr_len     = '0;
        acc         = '0;
        uuid_hits   = '1;
        tx_ok       = 1'b0;
        tx_nul      = 1'b0;
        tx_xml      = 1'b0;
        pkt_dir     = 1'b0;
        hdr_id      = '0;
    endtask

    // advance the predicted parser by one accepted byte
    task automatic parse_byte(input logic [7:0] b, input logic dir, input logic start);
        t_parser_event ev;
        logic fire;
        logic req;
        logic plain;
        logic [6:0] op;
        logic [1:0] cls;
        int k;
        int i;
        ev = '0;
        fire = 1'b0;
        if (start || phase == PH_IDLE) begin
            cur_code  = b;
            pkt_dir   = dir;
            pkt_count = 16'd1;
            pkt_len   = '0;
            phase     = PH_LEN_HI;
            return;
        end
        pkt_count = pkt_count + 16'd1;
        op    = cur_code[6:0];
        req   = (op < REQ_LIMIT) || (op == OP_ABORT);
        plain = (b >= 8'h20) || (b == 8'h0A);
        case (phase)
            PH_LEN_HI: begin
                pkt_len = {b, 8'h00};
                phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                pkt_len = pkt_len | b;
                if (pkt_len < 16'd3) pkt_len = 16'd3;
                fire = 1'b1;
                ev.kind = EV_HEAD;
                ev.length_value = pkt_len;
                if (req) last_req[pkt_dir] = op;
                hdr_count = '0;
                acc = '0;
                if (op == OP_CONNECT) begin
                    phase = PH_CONNECT;
                end else if (op == OP_SETPATH) begin
                    phase = PH_SETPATH;
                end else if (op == OP_DISCONNECT || op == OP_PUT || op == OP_GET
                             || op == OP_ABORT) begin
                    phase = PH_HDR_ID;
                end else if (last_req[!pkt_dir] == OP_CONNECT) begin
                    // reply to a connect from the far side
                    phase = PH_CONNECT;
                end else begin
                    phase = PH_HDR_ID;
                end
            end
            PH_CONNECT, PH_SETPATH: begin
                acc = {acc[23:0], b};
                hdr_count = hdr_count + 16'd1;
                if (phase == PH_CONNECT && hdr_count == 16'd4) begin
                    fire = 1'b1;
                    ev.kind = EV_CONNECT;
                    ev.field_value = {16'd0, acc[31:16]};
                    ev.length_value = acc[15:0];
                    phase = PH_HDR_ID;
                end else if (phase == PH_SETPATH && hdr_count == 16'd2) begin
                    fire = 1'b1;
                    ev.kind = EV_SETPATH;
                    ev.field_value = {16'd0, acc[15:0]};
                    phase = PH_HDR_ID;
                end
            end
            PH_HDR_ID: begin
                hdr_id = b;
                hdr_count = 16'd1;
                acc = '0;
                uuid_hits = '1;
                tx_ok = 1'b1;
                tx_nul = 1'b0;
                tx_xml = 1'b1;
                if (b[7:6] == CLS_ONE_BYTE) begin
                    hdr_len = 16'd2;
                    phase = PH_HDR_VALUE;
                end else if (b[7:6] == CLS_FOUR_BYTE) begin
                    hdr_len = 16'd5;
                    phase = PH_HDR_VALUE;
                end else begin
                    phase = PH_HDR_LEN_HI;
                end
            end
            PH_HDR_LEN_HI: begin
                hdr_len = {b, 8'h00};
                hdr_count = 16'd2;
                phase = PH_HDR_LEN_LO;
            end
            PH_HDR_LEN_LO: begin
                hdr_len = hdr_len | b;
                if (hdr_len < MIN_LEN) hdr_len = MIN_LEN;
                hdr_count = 16'd3;
                if (hdr_len == MIN_LEN) begin
                    fire = 1'b1;
                    ev.kind = EV_HEADER;
                    ev.header_id = hdr_id;
                    ev.length_value = MIN_LEN;
                    phase = PH_HDR_ID;
                end else begin
                    phase = PH_HDR_VALUE;
                end
            end
            PH_HDR_VALUE: begin
                cls = hdr_id[7:6];
                if (cls >= CLS_ONE_BYTE) begin
                    acc = {acc[23:0], b};
                end else begin
                    k = int'(hdr_count) - 3;
                    if (cls == CLS_BYTES) begin
                        if (k < 16) begin
                            for (i = 0; i < UUID_ROWS; i++)
                                if (uuid_byte(i, k) != b) uuid_hits[i] = 1'b0;
                        end
                        if (k < 5 && XML_OPENING[39 - 8 * k -: 8] != b) tx_xml = 1'b0;
                    end else if (k % 2 == 0) begin
                        acc = {24'd0, b};
                    end else if (!tx_nul) begin
                        // low byte of a unicode char, high byte held in acc
                        if (acc == 32'd0 && b == 8'h00) tx_nul = 1'b1;
                        else if (!plain) tx_ok = 1'b0;
                    end
                end
                hdr_count = hdr_count + 16'd1;
                if (hdr_count >= hdr_len) begin
                    fire = 1'b1;
                    ev.kind = EV_HEADER;
                    ev.header_id = hdr_id;
                    ev.length_value = hdr_len;
                    if (cls >= CLS_ONE_BYTE) begin
                        ev.field_value = acc;
                    end else if (cls == CLS_BYTES) begin
                        ev.is_xml = tx_xml && (hdr_len >= MIN_XML_LEN);
                        ev.is_text = !ev.is_xml && tx_ok && (b == 8'h00);
                        if ((hdr_id == HID_TARGET || hdr_id == HID_WHO)
                            && hdr_len == TARGET_HDR_LEN)
                            ev.target_mask = uuid_hits;
                    end else begin
                        ev.is_text = tx_nul && tx_ok;
                    end
                    phase = PH_HDR_ID;
                end else if (cls == CLS_BYTES && !plain) begin
                    tx_ok = 1'b0;
                end
            end
            default: phase = PH_IDLE;
        endcase
        if (phase != PH_LEN_HI && phase != PH_LEN_LO && pkt_count >= pkt_len)
            phase = PH_IDLE;
        if (fire) begin
            ev.code = op;
            ev.fin_bit = cur_code[7];
            ev.is_request = req;
            ev.packet_last = (phase == PH_IDLE);
            ev.direction = pkt_dir;
            pending_events.push_back(ev);
        end
    endtask

    // hand one word to the parser, with bursts and gaps on the sending side
    task automatic send_byte(input logic [7:0] b, input logic dir, input logic start);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_direction    <= dir;
        i_packet_start <= start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_byte(b, dir, start);
        bytes_fed++;
    endtask

    task automatic open_frame(input logic [7:0] first);
        frame = {};
        frame.push_back(first);
        frame.push_back(8'h00);
        frame.push_back(8'h00);
    endtask

    task automatic set_length(input int n);
        frame[1] = n[15:8];
        frame[2] = n[7:0];
    endtask

    task automatic send_frame(input logic dir, input logic first_start);
        int i;
        for (i = 0; i < frame.size(); i++)
            send_byte(frame[i], (i == 0) ? dir : 1'($urandom),
                      (i == 0) ? first_start : 1'b0);
    endtask

    // append a header built from hdr_value, with a length field for the string classes
    task automatic add_tlv(input logic [7:0] id);
        int n;
        int i;
        frame.push_back(id);
        if (id[7:6] < CLS_ONE_BYTE) begin
            n = hdr_value.size() + 3;
            frame.push_back(n[15:8]);
            frame.push_back(n[7:0]);
        end
        for (i = 0; i < hdr_value.size(); i++) frame.push_back(hdr_value[i]);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) hdr_value.push_back(s[i]);
    endtask

    task automatic load_uuid(input int row);
        int k;
        hdr_value = {};
        for (k = 0; k < 16; k++) hdr_value.push_back(uuid_byte(row, k));
    endtask

    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 8'h0A;
        else if (r < 17) return 8'($urandom_range(8'h20, 8'h7E));
        else return 8'($urandom);
    endfunction

    task automatic random_unicode_header();
        int n_chars;
        int nul_at;
        int i;
        hdr_value = {};
        n_chars = $urandom_range(0, 6);
        nul_at = ($urandom_range(0, 4) != 0) ? $urandom_range(0, n_chars) : -1;
        for (i = 0; i <= n_chars; i++) begin
            if (i == nul_at) begin
                hdr_value.push_back(8'h00);
                hdr_value.push_back(8'h00);
            end
            if (i < n_chars) begin
                hdr_value.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
                hdr_value.push_back(text_char());
            end
        end
        if ($urandom_range(0, 3) == 0) hdr_value.push_back(8'($urandom));
        add_tlv($urandom_range(0, 1) ? 8'h01 : {2'b00, 6'($urandom)});
    endtask

    task automatic random_bytes_header();
        t_byteseq_style style;
        logic [7:0] id;
        int n;
        int i;
        int j;
        hdr_value = {};
        id = {2'b01, 6'($urandom)};
        style = t_byteseq_style'($urandom_range(0, 3));
        case (style)
            BS_TEXT: begin
                n = $urandom_range(0, 8);
                for (i = 0; i < n; i++) hdr_value.push_back(text_char());
                if ($urandom_range(0, 4) != 0) hdr_value.push_back(8'h00);
            end
            BS_XML: begin
                push_text("<?xml");
                n = $urandom_range(0, 6);
                for (i = 0; i < n; i++) hdr_value.push_back(text_char());
                if ($urandom_range(0, 4) == 0)
                    hdr_value[$urandom_range(0, 4)] = 8'($urandom);
                if ($urandom_range(0, 4) == 0) begin
                    n = $urandom_range(1, 4);
                    while (hdr_value.size() > n) void'(hdr_value.pop_back());
                end
                if ($urandom_range(0, 2) == 0) hdr_value.push_back(8'h00);
            end
            BS_TARGET: begin
                if ($urandom_range(0, 4) != 0) id = $urandom_range(0, 1) ? HID_TARGET : HID_WHO;
                load_uuid($urandom_range(0, UUID_ROWS - 1));
                if ($urandom_range(0, 3) == 0) begin
                    j = $urandom_range(0, 15);
                    hdr_value[j] = hdr_value[j] ^ (8'd1 << $urandom_range(0, 7));
                end
                if ($urandom_range(0, 9) == 0) void'(hdr_value.pop_back());
                else if ($urandom_range(0, 9) == 0) hdr_value.push_back(8'h00);
            end
            default: begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 10);
                for (i = 0; i < n; i++) hdr_value.push_back(8'($urandom));
            end
        endcase
        add_tlv(id);
    endtask

    task automatic random_header();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1: random_unicode_header();
            6: begin
                // string header whose declared length is short or empty
                frame.push_back({1'b0, 1'($urandom), 6'($urandom)});
                frame.push_back(8'h00);
                frame.push_back(8'($urandom_range(0, 3)));
            end
            7: begin
                hdr_value = {8'($urandom)};
                add_tlv({CLS_ONE_BYTE, 6'($urandom)});
            end
            8: begin
                hdr_value = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
                add_tlv({CLS_FOUR_BYTE, 6'($urandom)});
            end
            default: random_bytes_header();
        endcase
    endtask

    task automatic random_packet();
        logic [6:0] op;
        logic dir;
        int pick;
        int n_hdrs;
        int declared;
        int i;
        pick = $urandom_range(0, 9);
        case (pick)
            0: op = OP_CONNECT;
            1: op = OP_DISCONNECT;
            2: op = OP_PUT;
            3: op = OP_GET;
            4: op = OP_SETPATH;
            5: op = OP_ABORT;
            6: op = 7'($urandom_range(4, 15));
            default: op = 7'($urandom_range(16, 126));
        endcase
        if (pick < 7) begin
            dir = 1'($urandom);
            req_dir = dir;
        end else begin
            dir = ($urandom_range(0, 3) != 0) ? !req_dir : 1'($urandom);
        end
        open_frame({1'($urandom), op});
        if (op == OP_CONNECT
            || (!(op == OP_DISCONNECT || op == OP_PUT || op == OP_GET || op == OP_SETPATH
                  || op == OP_ABORT) && last_req[!dir] == OP_CONNECT)) begin
            for (i = 0; i < 4; i++) frame.push_back(8'($urandom));
        end else if (op == OP_SETPATH) begin
            frame.push_back(8'($urandom));
            frame.push_back(8'($urandom));
        end
        n_hdrs = $urandom_range(0, 4);
        for (i = 0; i < n_hdrs; i++) random_header();
        pick = $urandom_range(0, 19);
        if (pick == 0) declared = $urandom_range(0, frame.size() - 1);
        else if (pick == 1) declared = frame.size() + $urandom_range(1, 6);
        else declared = frame.size();
        set_length(declared);
        send_frame(dir, resync || $urandom_range(0, 1));
        resync = (declared != frame.size());
    endtask

    task automatic test_connect_exchange();
        open_frame({1'b1, OP_CONNECT});
        frame.push_back(8'h10);
        frame.push_back(8'h00);
        frame.push_back(8'hFF);
        frame.push_back(8'hFF);
        load_uuid(0);
        add_tlv(HID_TARGET);
        set_length(frame.size());
        send_frame(1'b0, 1'b1);
        // success response on the other side carries connect fields too
        open_frame(8'hA0);
        frame.push_back(8'h10);
        frame.push_back(8'h80);
        frame.push_back(8'h00);
        frame.push_back(8'h00);
        load_uuid(9);
        add_tlv(HID_WHO);
        hdr_value = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
        add_tlv(8'hCB);
        set_length(frame.size());
        send_frame(1'b1, 1'b1);
    endtask

    task automatic test_setpath_unicode();
        open_frame({1'b1, OP_SETPATH});
        frame.push_back(8'h03);
        frame.push_back(8'hFF);
        // terminated name with a trailing odd byte
        hdr_value = {8'h00, 8'h61, 8'h00, 8'h0A, 8'h00, 8'h00, 8'h41};
        add_tlv(8'h01);
        hdr_value = {8'h00, 8'h61, 8'h01, 8'h05, 8'h00, 8'h00};
        add_tlv(8'h05);
        // no zero char at all
        hdr_value = {8'h00, 8'h41, 8'h00, 8'h42};
        add_tlv(8'h01);
        set_length(frame.size());
        send_frame(1'b0, 1'b1);
    endtask

    task automatic test_header_classes();
        open_frame({1'b0, OP_PUT});
        hdr_value = {};
        push_text("<?xml v");
        hdr_value.push_back(8'h00);
        add_tlv(8'h42);
        hdr_value = {};
        push_text("ab\n");
        hdr_value.push_back(8'h00);
        add_tlv(8'h42);
        hdr_value = {};
        push_text("<?xm");
        add_tlv(8'h42);
        hdr_value = {8'h01, 8'h00};
        add_tlv(8'h48);
        hdr_value = {};
        add_tlv(8'h49);
        // declared lengths of zero and two count as three
        frame.push_back(8'h05);
        frame.push_back(8'h00);
        frame.push_back(8'h00);
        frame.push_back(8'h44);
        frame.push_back(8'h00);
        frame.push_back(8'h02);
        hdr_value = {8'hFF};
        add_tlv(8'h97);
        hdr_value = {8'h00, 8'h00, 8'h00, 8'h00};
        add_tlv(8'hC0);
        hdr_value = {8'h80, 8'h00, 8'h00, 8'h01};
        add_tlv(8'hFF);
        set_length(frame.size());
        send_frame(1'b1, 1'b1);
    endtask

    task automatic test_packet_boundaries();
        // packets that close with their head, then one with a single one-byte header
        frame = {8'h83, 8'h00, 8'h00};
        send_frame(1'b0, 1'b0);
        frame = {8'hFF, 8'h00, 8'h01};
        send_frame(1'b1, 1'b1);
        open_frame(8'h10);
        hdr_value = {8'h12};
        add_tlv(8'h88);
        set_length(frame.size());
        send_frame(1'b1, 1'b1);
        // packet ends inside a header
        open_frame({1'b1, OP_PUT});
        hdr_value = {};
        push_text("truncated");
        add_tlv(8'h42);
        set_length(8);
        send_frame(1'b0, 1'b1);
        // packet ends inside the connect fields
        open_frame({1'b1, OP_CONNECT});
        frame.push_back(8'h10);
        frame.push_back(8'h00);
        frame.push_back(8'h01);
        frame.push_back(8'h00);
        set_length(5);
        send_frame(1'b0, 1'b1);
        // long packet cut short by a forced start
        open_frame({1'b1, OP_DISCONNECT});
        hdr_value = {8'h00, 8'h00, 8'h00, 8'h07};
        add_tlv(8'hCB);
        set_length(16'h0100);
        send_frame(1'b0, 1'b1);
        frame = {{1'b1, OP_DISCONNECT}, 8'h00, 8'h03};
        send_frame(1'b0, 1'b1);
    endtask

    task automatic test_random_traffic();
        int target;
        int n;
        int i;
        target = bytes_fed + RANDOM_BYTES;
        while (bytes_fed < target) begin
            if ($urandom_range(0, 9) < 8) begin
                random_packet();
            end else begin
                n = $urandom_range(1, 12);
                for (i = 0; i < n; i++)
                    send_byte(8'($urandom), 1'($urandom), $urandom_range(0, 6) == 0);
                resync = 1'b1;
            end
        end
    endtask

    // receiver stalls, switching between a few patterns
    int rx_mode = RX_OPEN;
    int rx_hold = 0;
    int rx_tick = 0;

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_hold == 0) begin
            rx_mode <= $urandom_range(RX_OPEN, RX_PERIODIC);
            rx_hold <= $urandom_range(40, 300);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:  i_out_ready <= 1'b1;
            RX_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: i_out_ready <= ($urandom_range(0, 9) < 3);
            default:  i_out_ready <= ((rx_tick % 7) > 1);
        endcase
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            if (error_count < REPORT_LIMIT)
                $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : event_check
        t_parser_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                if (error_count < REPORT_LIMIT)
                    $display("%0t ns: unexpected event, expected none, got kind %0d code %h",
                             $time, o_event_kind, o_code);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                compare_field("event_kind", want.kind, o_event_kind);
                compare_field("code", want.code, o_code);
                compare_field("fin_bit", want.fin_bit, o_fin_bit);
                compare_field("is_request", want.is_request, o_is_request);
                compare_field("length_value", want.length_value, o_length_value);
                compare_field("field_value", want.field_value, o_field_value);
                compare_field("header_id", want.header_id, o_header_id);
                compare_field("target_mask", want.target_mask, o_target_mask);
                compare_field("is_text", want.is_text, o_is_text);
                compare_field("is_xml", want.is_xml, o_is_xml);
                compare_field("packet_last", want.packet_last, o_packet_last);
                compare_field("event_direction", want.direction, o_event_direction);
            end
        end
    end

    // no word moving on either side for too long means the run is stuck
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL obex_packet_parser_unit");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_connect_exchange();
        test_setpath_unicode();
        test_header_classes();
        test_packet_boundaries();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS obex_packet_parser_unit");
        else
            $display("FAIL obex_packet_parser_unit");
        $finish;
    end

endmodule
